@@ src/rgbxy_pkg.sv @@
`timescale 1ns / 1ps

package rgbxy_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_X        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_Y        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_Y       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OFF_ON_BLACK = 3'd7;

	// reset values of the gamut corners, Q0.16
	localparam logic [31:0] RST_RED_X   = 32'd46137;
	localparam logic [31:0] RST_RED_Y   = 32'd19399;
	localparam logic [31:0] RST_GREEN_X = 32'd14097;
	localparam logic [31:0] RST_GREEN_Y = 32'd46570;
	localparam logic [31:0] RST_BLUE_X  = 32'd9044;
	localparam logic [31:0] RST_BLUE_Y  = 32'd5243;
	localparam logic [15:0] RST_FACTOR  = 16'd256;

	localparam int LIN_W  = 16;
	localparam int COEF_W = 20;
	localparam int PROD_W = LIN_W + COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int TQ_BITS = 30;

	// RGB to XYZ, Q0.20, row major
	typedef logic [COEF_W-1:0] mtx_t [9];
	localparam mtx_t MTX = '{
		20'd696790, 20'd161820, 20'd169899,
		20'd297671, 20'd700903, 20'd50001,
		20'd92,     20'd75823,  20'd1033937
	};

	typedef enum logic [1:0] {
		EP_START,
		EP_END,
		EP_MID
	} edge_pos_t;

	typedef struct packed {
		logic [LIN_W-1:0] level;
		logic [7:0]       lamp;
		logic             on;
		logic             black;
	} side_t;

	typedef logic [LIN_W-1:0] lin_table_t [256];

	// sRGB decode curve, Q0.16, evaluated at elaboration
	function automatic lin_table_t lin_table_build();
		lin_table_t tab;
		longint unsigned u;
		longint unsigned u2;
		longint unsigned r;
		longint unsigned t;
		longint unsigned p;
		longint unsigned v;
		longint unsigned lin;
		longint unsigned cc;
		for (int c = 0; c < 256; c++) begin
			cc = longint'(c);
			if (c <= 10) begin
				lin = (cc * 64'd13107200 + 64'd329460) / 64'd658920;
			end else begin
				u = (((64'd1000 * cc + 64'd14025) << 30) + 64'd134512) / 64'd269025;
				u2 = (u * u + (64'd1 << 29)) >> 30;
				r = 0;
				for (int b = 30; b >= 0; b--) begin
					t = r | (64'd1 << b);
					p = t;
					for (int i = 0; i < 4; i++) begin
						p = (p * t) >> 30;
					end
					if (t <= (64'd1 << 30) && p <= u2) begin
						r = t;
					end
				end
				v = (u2 * r) >> 30;
				lin = (v + 64'd8192) >> 14;
				if (lin > 64'd65535) begin
					lin = 64'd65535;
				end
			end
			tab[c] = lin[LIN_W-1:0];
		end
		return tab;
	endfunction

endpackage

@@ src/rgb_to_xy_gamut_clamp.sv @@
`timescale 1ns / 1ps

// Throughput: one pixel per cycle while out_ready is high; the COORD_FRAC_BITS + 1 stage
// chroma divider and the 30 stage edge-parameter divider are fully pipelined, one bit a
// stage. Stalls close bubbles stage by stage; input is taken while a result waits, as
// long as an empty stage lies ahead of it.
// Reset (arst_n low, async) empties the pipe and loads register defaults.
module rgb_to_xy_gamut_clamp #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write_en,
	input  logic [rgbxy_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [((COORD_FRAC_BITS > 16) ? COORD_FRAC_BITS : 16)-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic out_valid,
	input  logic out_ready,
	output logic [COORD_FRAC_BITS-1:0] chroma_x,
	output logic [COORD_FRAC_BITS-1:0] chroma_y,
	output logic [15:0] linear_level,
	output logic [7:0] lamp_level,
	output logic lamp_on,
	output logic was_clamped
);

	localparam int F     = COORD_FRAC_BITS;
	localparam int LW    = rgbxy_pkg::LIN_W;
	localparam int PRW   = rgbxy_pkg::PROD_W;
	localparam int SW    = rgbxy_pkg::SUM_W;
	localparam int TQ    = rgbxy_pkg::TQ_BITS;
	localparam int NW    = SW + F + 1;
	localparam int PW    = F + 2;
	localparam int PPW   = 2 * PW;
	localparam int CW    = 2 * F + 6;
	localparam int RW    = 2 * F + 2;
	localparam int MW    = F + TQ;
	localparam int DSW   = PPW + 1;

	localparam int ST_DIV = 5;
	localparam int ST_S6  = F + 6;
	localparam int ST_S7  = F + 7;
	localparam int ST_S8  = F + 8;
	localparam int ST_TD  = F + 9;
	localparam int ST_S9  = ST_TD + TQ;
	localparam int ST_S10 = ST_S9 + 1;
	localparam int ST_S11 = ST_S9 + 2;
	localparam int ST_S12 = ST_S9 + 3;
	localparam int ST_S13 = ST_S9 + 4;
	localparam int N_STG  = ST_S13 + 1;

	localparam rgbxy_pkg::lin_table_t LIN = rgbxy_pkg::lin_table_build();
	localparam logic [40:0] LAMP_CAP = 41'd254 << 24;
	localparam logic [MW:0] T_HALF = (MW+1)'(1) << (TQ - 1);

	// ---------------- configuration ----------------
	logic [F-1:0] red_x_q, red_y_q, green_x_q, green_y_q, blue_x_q, blue_y_q;
	logic [15:0]  factor_q;
	logic         off_on_black_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_x_q        <= rgbxy_pkg::RST_RED_X[F-1:0];
			red_y_q        <= rgbxy_pkg::RST_RED_Y[F-1:0];
			green_x_q      <= rgbxy_pkg::RST_GREEN_X[F-1:0];
			green_y_q      <= rgbxy_pkg::RST_GREEN_Y[F-1:0];
			blue_x_q       <= rgbxy_pkg::RST_BLUE_X[F-1:0];
			blue_y_q       <= rgbxy_pkg::RST_BLUE_Y[F-1:0];
			factor_q       <= rgbxy_pkg::RST_FACTOR;
			off_on_black_q <= 1'b1;
		end else if (cfg_write_en) begin
			case (cfg_index)
				rgbxy_pkg::CFG_RED_X:        red_x_q        <= cfg_data[F-1:0];
				rgbxy_pkg::CFG_RED_Y:        red_y_q        <= cfg_data[F-1:0];
				rgbxy_pkg::CFG_GREEN_X:      green_x_q      <= cfg_data[F-1:0];
				rgbxy_pkg::CFG_GREEN_Y:      green_y_q      <= cfg_data[F-1:0];
				rgbxy_pkg::CFG_BLUE_X:       blue_x_q       <= cfg_data[F-1:0];
				rgbxy_pkg::CFG_BLUE_Y:       blue_y_q       <= cfg_data[F-1:0];
				rgbxy_pkg::CFG_FACTOR:       factor_q       <= cfg_data[15:0];
				rgbxy_pkg::CFG_OFF_ON_BLACK: off_on_black_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// edges in tie order: red->green, blue->red, green->blue
	logic signed [PW-1:0] ax_c [3];
	logic signed [PW-1:0] ay_c [3];
	logic signed [PW-1:0] bx_c [3];
	logic signed [PW-1:0] by_c [3];
	logic signed [PW-1:0] dx_c [3];
	logic signed [PW-1:0] dy_c [3];
	logic signed [PW-1:0] adx_c [3];
	logic signed [PW-1:0] ady_c [3];

	always_comb begin
		ax_c[0] = $signed({2'b00, red_x_q});
		ay_c[0] = $signed({2'b00, red_y_q});
		bx_c[0] = $signed({2'b00, green_x_q});
		by_c[0] = $signed({2'b00, green_y_q});
		ax_c[1] = $signed({2'b00, blue_x_q});
		ay_c[1] = $signed({2'b00, blue_y_q});
		bx_c[1] = $signed({2'b00, red_x_q});
		by_c[1] = $signed({2'b00, red_y_q});
		ax_c[2] = $signed({2'b00, green_x_q});
		ay_c[2] = $signed({2'b00, green_y_q});
		bx_c[2] = $signed({2'b00, blue_x_q});
		by_c[2] = $signed({2'b00, blue_y_q});
		for (int e = 0; e < 3; e++) begin
			dx_c[e]  = bx_c[e] - ax_c[e];
			dy_c[e]  = by_c[e] - ay_c[e];
			adx_c[e] = dx_c[e][PW-1] ? -dx_c[e] : dx_c[e];
			ady_c[e] = dy_c[e][PW-1] ? -dy_c[e] : dy_c[e];
		end
	end

	// ---------------- pipeline flow control ----------------
	logic [N_STG-1:0] vld_q;
	logic [N_STG-1:0] load;

	for (genvar k = 0; k < N_STG; k++) begin : g_load
		assign load[k] = out_ready | ~(&vld_q[N_STG-1:k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < N_STG; k++) begin
				if (load[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = load[0];
	assign out_valid = vld_q[N_STG-1];

	// ---------------- s1: decode curve ----------------
	logic [LW-1:0] lin_s1 [3];

	always_ff @(posedge clk) begin
		if (load[0]) begin
			lin_s1[0] <= LIN[red];
			lin_s1[1] <= LIN[green];
			lin_s1[2] <= LIN[blue];
		end
	end

	// ---------------- s2: matrix products, brightness ----------------
	logic [PRW-1:0]    prod_s2 [9];
	rgbxy_pkg::side_t  side_s2;
	logic [LW-1:0]     max_rg, max_rgb;

	always_comb begin
		max_rg  = (lin_s1[1] > lin_s1[0]) ? lin_s1[1] : lin_s1[0];
		max_rgb = (lin_s1[2] > max_rg) ? lin_s1[2] : max_rg;
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s2[3*j+i] <= PRW'(rgbxy_pkg::MTX[3*j+i]) * PRW'(lin_s1[i]);
				end
			end
			side_s2.level <= max_rgb;
			side_s2.lamp  <= '0;
			side_s2.black <= (max_rgb == '0);
			side_s2.on    <= !(off_on_black_q && (max_rgb == '0));
		end
	end

	// ---------------- s3: X, Y, Z ----------------
	logic [SW-1:0]    xyz_s3 [3];
	logic [23:0]      m_s3;
	rgbxy_pkg::side_t side_s3;
	logic [23:0]      lvl254;

	assign lvl254 = 24'(side_s2.level) * 24'd254;

	always_ff @(posedge clk) begin
		if (load[2]) begin
			for (int j = 0; j < 3; j++) begin
				xyz_s3[j] <= SW'(prod_s2[3*j]) + SW'(prod_s2[3*j+1]) + SW'(prod_s2[3*j+2]);
			end
			m_s3    <= (lvl254 < 24'd65536) ? 24'd65536 : lvl254;
			side_s3 <= side_s2;
		end
	end

	// ---------------- s4: sum, lamp product ----------------
	logic [SW-1:0]    x_s4, y_s4, s_s4;
	logic [39:0]      p_s4;
	rgbxy_pkg::side_t side_s4;

	always_ff @(posedge clk) begin
		if (load[3]) begin
			x_s4    <= xyz_s3[0];
			y_s4    <= xyz_s3[1];
			s_s4    <= xyz_s3[0] + xyz_s3[1] + xyz_s3[2];
			p_s4    <= 40'(factor_q) * 40'(m_s3);
			side_s4 <= side_s3;
		end
	end

	// ---------------- s5 and chroma divider ----------------
	// entry 0 is the s5 register, entry j+1 the output of divider stage j
	logic [NW-1:0]    xrem_sd [F+2];
	logic [NW-1:0]    yrem_sd [F+2];
	logic [SW-1:0]    den_sd  [F+2];
	logic [F:0]       xq_sd   [F+2];
	logic [F:0]       yq_sd   [F+2];
	rgbxy_pkg::side_t side_sd [F+2];
	logic [40:0]      p_cap, p_rnd;

	always_comb begin
		p_cap = (41'(p_s4) > LAMP_CAP) ? LAMP_CAP : 41'(p_s4);
		p_rnd = p_cap + (41'd1 << 23);
	end

	always_ff @(posedge clk) begin
		if (load[4]) begin
			xrem_sd[0] <= (NW'(x_s4) << F) + NW'(s_s4 >> 1);
			yrem_sd[0] <= (NW'(y_s4) << F) + NW'(s_s4 >> 1);
			den_sd[0]  <= s_s4;
			xq_sd[0]   <= '0;
			yq_sd[0]   <= '0;
			side_sd[0].level <= side_s4.level;
			side_sd[0].on    <= side_s4.on;
			side_sd[0].black <= side_s4.black;
			side_sd[0].lamp  <= side_s4.on ? p_rnd[31:24] : 8'd0;
		end
	end

	for (genvar j = 0; j <= F; j++) begin : g_cdiv
		localparam int B = F - j;
		logic [NW-1:0] dsh;
		logic          xge, yge;

		assign dsh = NW'(den_sd[j]) << B;
		assign xge = (xrem_sd[j] >= dsh);
		assign yge = (yrem_sd[j] >= dsh);

		always_ff @(posedge clk) begin
			if (load[ST_DIV+j]) begin
				xrem_sd[j+1] <= xge ? (xrem_sd[j] - dsh) : xrem_sd[j];
				yrem_sd[j+1] <= yge ? (yrem_sd[j] - dsh) : yrem_sd[j];
				xq_sd[j+1]   <= xq_sd[j] | ((F+1)'(xge) << B);
				yq_sd[j+1]   <= yq_sd[j] | ((F+1)'(yge) << B);
				den_sd[j+1]  <= den_sd[j];
				side_sd[j+1] <= side_sd[j];
			end
		end
	end

	// ---------------- s6: gamut and edge products ----------------
	logic signed [PW-1:0]  px_c, py_c, qx_c, qy_c, v1x_c, v1y_c, v2x_c, v2y_c;
	logic signed [PPW-1:0] pin_s6  [6];
	logic signed [PPW-1:0] dotp_s6 [3][2];
	logic signed [PPW-1:0] lenp_s6 [3][2];
	logic [F:0]            px_s6, py_s6;
	rgbxy_pkg::side_t      side_s6;

	always_comb begin
		px_c  = $signed({1'b0, xq_sd[F+1]});
		py_c  = $signed({1'b0, yq_sd[F+1]});
		qx_c  = px_c - ax_c[0];
		qy_c  = py_c - ay_c[0];
		v1x_c = dx_c[0];
		v1y_c = dy_c[0];
		v2x_c = ax_c[1] - ax_c[0];
		v2y_c = ay_c[1] - ay_c[0];
	end

	always_ff @(posedge clk) begin
		if (load[ST_S6]) begin
			pin_s6[0] <= qx_c * v2y_c;
			pin_s6[1] <= qy_c * v2x_c;
			pin_s6[2] <= v1x_c * qy_c;
			pin_s6[3] <= v1y_c * qx_c;
			pin_s6[4] <= v1x_c * v2y_c;
			pin_s6[5] <= v1y_c * v2x_c;
			for (int e = 0; e < 3; e++) begin
				dotp_s6[e][0] <= (px_c - ax_c[e]) * dx_c[e];
				dotp_s6[e][1] <= (py_c - ay_c[e]) * dy_c[e];
				lenp_s6[e][0] <= dx_c[e] * dx_c[e];
				lenp_s6[e][1] <= dy_c[e] * dy_c[e];
			end
			px_s6   <= xq_sd[F+1];
			py_s6   <= yq_sd[F+1];
			side_s6 <= side_sd[F+1];
		end
	end

	// ---------------- s7: cross products, dot, length ----------------
	logic signed [CW-1:0] cs_s7, ct_s7, d_s7;
	logic signed [CW-1:0] dot_s7  [3];
	logic signed [CW-1:0] len2_s7 [3];
	logic [F:0]           px_s7, py_s7;
	rgbxy_pkg::side_t     side_s7;

	always_ff @(posedge clk) begin
		if (load[ST_S7]) begin
			cs_s7 <= CW'(pin_s6[0]) - CW'(pin_s6[1]);
			ct_s7 <= CW'(pin_s6[2]) - CW'(pin_s6[3]);
			d_s7  <= CW'(pin_s6[4]) - CW'(pin_s6[5]);
			for (int e = 0; e < 3; e++) begin
				dot_s7[e]  <= CW'(dotp_s6[e][0]) + CW'(dotp_s6[e][1]);
				len2_s7[e] <= CW'(lenp_s6[e][0]) + CW'(lenp_s6[e][1]);
			end
			px_s7   <= px_s6;
			py_s7   <= py_s6;
			side_s7 <= side_s6;
		end
	end

	// ---------------- s8: inside test, edge cases; edge divider ----------------
	logic [RW-1:0]         trem_st [TQ+1][3];
	logic [RW-1:0]         tden_st [TQ+1][3];
	logic [TQ-1:0]         tq_st   [TQ+1][3];
	rgbxy_pkg::edge_pos_t  mode_st [TQ+1][3];
	logic [F:0]            px_st   [TQ+1];
	logic [F:0]            py_st   [TQ+1];
	logic                  clamp_st [TQ+1];
	rgbxy_pkg::side_t      side_st [TQ+1];
	logic signed [CW-1:0]  cst_sum;
	logic                  in_gamut;

	always_comb begin
		cst_sum = cs_s7 + ct_s7;
		if (d_s7 > 0) begin
			in_gamut = (cs_s7 >= 0) && (ct_s7 >= 0) && (cst_sum <= d_s7);
		end else if (d_s7 < 0) begin
			in_gamut = (cs_s7 <= 0) && (ct_s7 <= 0) && (cst_sum >= d_s7);
		end else begin
			in_gamut = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load[ST_S8]) begin
			for (int e = 0; e < 3; e++) begin
				if (len2_s7[e] == 0 || dot_s7[e] <= 0) begin
					mode_st[0][e] <= rgbxy_pkg::EP_START;
				end else if (dot_s7[e] >= len2_s7[e]) begin
					mode_st[0][e] <= rgbxy_pkg::EP_END;
				end else begin
					mode_st[0][e] <= rgbxy_pkg::EP_MID;
				end
				trem_st[0][e] <= dot_s7[e][RW-1:0];
				tden_st[0][e] <= len2_s7[e][RW-1:0];
				tq_st[0][e]   <= '0;
			end
			px_st[0]    <= px_s7;
			py_st[0]    <= py_s7;
			clamp_st[0] <= !side_s7.black && !in_gamut;
			side_st[0]  <= side_s7;
		end
	end

	// t = floor(2^30 * dot / len2), one quotient bit a stage
	for (genvar j = 0; j < TQ; j++) begin : g_tdiv
		logic [RW-1:0] r2 [3];
		logic          ge [3];

		always_comb begin
			for (int e = 0; e < 3; e++) begin
				r2[e] = {trem_st[j][e][RW-2:0], 1'b0};
				ge[e] = (r2[e] >= tden_st[j][e]);
			end
		end

		always_ff @(posedge clk) begin
			if (load[ST_TD+j]) begin
				for (int e = 0; e < 3; e++) begin
					trem_st[j+1][e] <= ge[e] ? (r2[e] - tden_st[j][e]) : r2[e];
					tden_st[j+1][e] <= tden_st[j][e];
					tq_st[j+1][e]   <= {tq_st[j][e][TQ-2:0], ge[e]};
					mode_st[j+1][e] <= mode_st[j][e];
				end
				px_st[j+1]    <= px_st[j];
				py_st[j+1]    <= py_st[j];
				clamp_st[j+1] <= clamp_st[j];
				side_st[j+1]  <= side_st[j];
			end
		end
	end

	// ---------------- s9: step products ----------------
	logic [MW-1:0]        mgx_s9 [3];
	logic [MW-1:0]        mgy_s9 [3];
	rgbxy_pkg::edge_pos_t mode_s9 [3];
	logic [F:0]           px_s9, py_s9;
	logic                 clamp_s9;
	rgbxy_pkg::side_t     side_s9;

	always_ff @(posedge clk) begin
		if (load[ST_S9]) begin
			for (int e = 0; e < 3; e++) begin
				mgx_s9[e]  <= MW'(adx_c[e][F-1:0]) * MW'(tq_st[TQ][e]);
				mgy_s9[e]  <= MW'(ady_c[e][F-1:0]) * MW'(tq_st[TQ][e]);
				mode_s9[e] <= mode_st[TQ][e];
			end
			px_s9    <= px_st[TQ];
			py_s9    <= py_st[TQ];
			clamp_s9 <= clamp_st[TQ];
			side_s9  <= side_st[TQ];
		end
	end

	// ---------------- s10: nearest points ----------------
	logic signed [PW-1:0] ex_s10 [3];
	logic signed [PW-1:0] ey_s10 [3];
	logic [F:0]           px_s10, py_s10;
	logic                 clamp_s10;
	rgbxy_pkg::side_t     side_s10;
	logic [MW:0]          rndx [3];
	logic [MW:0]          rndy [3];
	logic signed [PW-1:0] stx [3];
	logic signed [PW-1:0] sty [3];
	logic signed [PW-1:0] midx [3];
	logic signed [PW-1:0] midy [3];

	always_comb begin
		for (int e = 0; e < 3; e++) begin
			rndx[e] = (MW+1)'(mgx_s9[e]) + T_HALF;
			rndy[e] = (MW+1)'(mgy_s9[e]) + T_HALF;
			stx[e]  = $signed({1'b0, rndx[e][MW:TQ]});
			sty[e]  = $signed({1'b0, rndy[e][MW:TQ]});
			midx[e] = dx_c[e][PW-1] ? (ax_c[e] - stx[e]) : (ax_c[e] + stx[e]);
			midy[e] = dy_c[e][PW-1] ? (ay_c[e] - sty[e]) : (ay_c[e] + sty[e]);
		end
	end

	always_ff @(posedge clk) begin
		if (load[ST_S10]) begin
			for (int e = 0; e < 3; e++) begin
				case (mode_s9[e])
					rgbxy_pkg::EP_END: begin
						ex_s10[e] <= bx_c[e];
						ey_s10[e] <= by_c[e];
					end
					rgbxy_pkg::EP_MID: begin
						ex_s10[e] <= midx[e];
						ey_s10[e] <= midy[e];
					end
					default: begin
						ex_s10[e] <= ax_c[e];
						ey_s10[e] <= ay_c[e];
					end
				endcase
			end
			px_s10    <= px_s9;
			py_s10    <= py_s9;
			clamp_s10 <= clamp_s9;
			side_s10  <= side_s9;
		end
	end

	// ---------------- s11: squared offsets ----------------
	logic signed [PPW-1:0] sqx_s11 [3];
	logic signed [PPW-1:0] sqy_s11 [3];
	logic signed [PW-1:0]  ex_s11 [3];
	logic signed [PW-1:0]  ey_s11 [3];
	logic [F:0]            px_s11, py_s11;
	logic                  clamp_s11;
	rgbxy_pkg::side_t      side_s11;
	logic signed [PW-1:0]  offx [3];
	logic signed [PW-1:0]  offy [3];

	always_comb begin
		for (int e = 0; e < 3; e++) begin
			offx[e] = $signed({1'b0, px_s10}) - ex_s10[e];
			offy[e] = $signed({1'b0, py_s10}) - ey_s10[e];
		end
	end

	always_ff @(posedge clk) begin
		if (load[ST_S11]) begin
			for (int e = 0; e < 3; e++) begin
				sqx_s11[e] <= offx[e] * offx[e];
				sqy_s11[e] <= offy[e] * offy[e];
				ex_s11[e]  <= ex_s10[e];
				ey_s11[e]  <= ey_s10[e];
			end
			px_s11    <= px_s10;
			py_s11    <= py_s10;
			clamp_s11 <= clamp_s10;
			side_s11  <= side_s10;
		end
	end

	// ---------------- s12: distances ----------------
	logic [DSW-1:0]       dist_s12 [3];
	logic signed [PW-1:0] ex_s12 [3];
	logic signed [PW-1:0] ey_s12 [3];
	logic [F:0]           px_s12, py_s12;
	logic                 clamp_s12;
	rgbxy_pkg::side_t     side_s12;

	always_ff @(posedge clk) begin
		if (load[ST_S12]) begin
			for (int e = 0; e < 3; e++) begin
				dist_s12[e] <= DSW'(unsigned'(sqx_s11[e])) + DSW'(unsigned'(sqy_s11[e]));
				ex_s12[e]   <= ex_s11[e];
				ey_s12[e]   <= ey_s11[e];
			end
			px_s12    <= px_s11;
			py_s12    <= py_s11;
			clamp_s12 <= clamp_s11;
			side_s12  <= side_s11;
		end
	end

	// ---------------- s13: pick edge, output register ----------------
	logic [DSW-1:0]       best01;
	logic signed [PW-1:0] nx01, ny01, nx, ny;

	always_comb begin
		// strict compares keep the earlier edge on a tie
		if (dist_s12[1] < dist_s12[0]) begin
			best01 = dist_s12[1];
			nx01   = ex_s12[1];
			ny01   = ey_s12[1];
		end else begin
			best01 = dist_s12[0];
			nx01   = ex_s12[0];
			ny01   = ey_s12[0];
		end
		if (dist_s12[2] < best01) begin
			nx = ex_s12[2];
			ny = ey_s12[2];
		end else begin
			nx = nx01;
			ny = ny01;
		end
	end

	always_ff @(posedge clk) begin
		if (load[ST_S13]) begin
			if (side_s12.black) begin
				chroma_x <= '0;
				chroma_y <= '0;
			end else if (clamp_s12) begin
				chroma_x <= nx[F-1:0];
				chroma_y <= ny[F-1:0];
			end else begin
				chroma_x <= px_s12[F-1:0];
				chroma_y <= py_s12[F-1:0];
			end
			linear_level <= side_s12.level;
			lamp_level   <= side_s12.lamp;
			lamp_on      <= side_s12.on;
			was_clamped  <= clamp_s12;
		end
	end

`ifndef SYNTHESIS
	a_lamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lamp_level <= 8'd254)
		else $error("lamp level above 254");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lamp_on |-> lamp_level == 8'd0)
		else $error("lamp off with nonzero level");

	a_off_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lamp_on |-> linear_level == 16'd0)
		else $error("lamp off on a lit pixel");

	a_black_xy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && linear_level == 16'd0 |->
			!was_clamped && chroma_x == '0 && chroma_y == '0)
		else $error("black pixel with chromaticity or clamp");
`endif

endmodule

@@ tb/tb_rgb_to_xy_gamut_clamp.sv @@
`timescale 1ns / 1ps

module tb_rgb_to_xy_gamut_clamp;

	localparam int F = 16;
	localparam int PIPE_LAT = F + 44;

	typedef struct {
		logic [F-1:0] cx;
		logic [F-1:0] cy;
		logic [15:0]  level;
		logic [7:0]   lamp;
		logic         on;
		logic         clamped;
	} xy_result_t;

	class xy_scoreboard;
		longint gamut[6];
		longint unsigned factor;
		bit off_black;
		xy_result_t pending[$];
		int errors;

		function new();
			restore();
			errors = 0;
		endfunction

		function void restore();
			gamut[0] = 46137; gamut[1] = 19399;
			gamut[2] = 14097; gamut[3] = 46570;
			gamut[4] = 9044;  gamut[5] = 5243;
			factor = 256;
			off_black = 1;
		endfunction

		function void set_reg(logic [rgbxy_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				rgbxy_pkg::CFG_RED_X:        gamut[0] = val;
				rgbxy_pkg::CFG_RED_Y:        gamut[1] = val;
				rgbxy_pkg::CFG_GREEN_X:      gamut[2] = val;
				rgbxy_pkg::CFG_GREEN_Y:      gamut[3] = val;
				rgbxy_pkg::CFG_BLUE_X:       gamut[4] = val;
				rgbxy_pkg::CFG_BLUE_Y:       gamut[5] = val;
				rgbxy_pkg::CFG_FACTOR:       factor = val;
				rgbxy_pkg::CFG_OFF_ON_BLACK: off_black = val[0];
				default: ;
			endcase
		endfunction

		// truncated fifth power in Q30
		function longint unsigned pow5(longint unsigned r);
			longint unsigned p;
			p = r;
			for (int i = 0; i < 4; i++)
				p = (p * r) >> 30;
			return p;
		endfunction

		function longint unsigned srgb_decode(longint unsigned c);
			longint unsigned u, u2, r, t, lin;
			if (c <= 10)
				return (c * 64'd13107200 + 64'd329460) / 64'd658920;
			u = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
			u2 = (u * u + (64'd1 << 29)) >> 30;
			r = 0;
			for (int b = 30; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t <= (64'd1 << 30)) begin
					if (pow5(t) <= u2)
						r = t;
				end
			end
			lin = (((u2 * r) >> 30) + 64'd8192) >> 14;
			return lin > 65535 ? 65535 : lin;
		endfunction

		function longint move_along(longint a, longint d, longint unsigned tq);
			longint unsigned mag, q;
			mag = d < 0 ? -d : d;
			q = (mag * tq + (64'd1 << 29)) >> 30;
			return d < 0 ? a - longint'(q) : a + longint'(q);
		endfunction

		function void edge_point(longint ax, longint ay, longint bx, longint by,
				longint px, longint py, output longint ox, output longint oy);
			longint dx, dy, len2, dot;
			longint unsigned rem, den, tq;
			dx = bx - ax;
			dy = by - ay;
			len2 = dx * dx + dy * dy;
			dot = (px - ax) * dx + (py - ay) * dy;
			if (len2 == 0 || dot <= 0) begin
				ox = ax; oy = ay;
			end else if (dot >= len2) begin
				ox = bx; oy = by;
			end else begin
				rem = dot;
				den = len2;
				tq = 0;
				for (int i = 0; i < 30; i++) begin
					rem = rem << 1;
					tq = tq << 1;
					if (rem >= den) begin
						rem = rem - den;
						tq = tq | 1;
					end
				end
				ox = move_along(ax, dx, tq);
				oy = move_along(ay, dy, tq);
			end
		endfunction

		function bit in_triangle(longint px, longint py);
			longint v1x, v1y, v2x, v2y, qx, qy, d, cs, ct;
			v1x = gamut[2] - gamut[0]; v1y = gamut[3] - gamut[1];
			v2x = gamut[4] - gamut[0]; v2y = gamut[5] - gamut[1];
			qx = px - gamut[0]; qy = py - gamut[1];
			d = v1x * v2y - v1y * v2x;
			cs = qx * v2y - qy * v2x;
			ct = v1x * qy - v1y * qx;
			if (d > 0)
				return cs >= 0 && ct >= 0 && cs + ct <= d;
			if (d < 0)
				return cs <= 0 && ct <= 0 && cs + ct >= d;
			return 0;
		endfunction

		function void note(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			longint unsigned lr, lg, lb, lvl, sx, sy, sz, ss, m, p, lamp;
			longint cx, cy, ex, ey, fx, fy, hx, hy, de, df, dh, best, nx, ny;
			xy_result_t res;
			lr = srgb_decode(r);
			lg = srgb_decode(g);
			lb = srgb_decode(b);
			lvl = lr;
			if (lg > lvl) lvl = lg;
			if (lb > lvl) lvl = lb;
			cx = 0;
			cy = 0;
			res.clamped = 0;
			if (lvl != 0) begin
				sx = 696790 * lr + 161820 * lg + 169899 * lb;
				sy = 297671 * lr + 700903 * lg + 50001 * lb;
				sz = 92 * lr + 75823 * lg + 1033937 * lb;
				ss = sx + sy + sz;
				if (ss != 0) begin
					cx = ((sx << F) + ss / 2) / ss;
					cy = ((sy << F) + ss / 2) / ss;
				end
				if (!in_triangle(cx, cy)) begin
					// edges in order red-green, blue-red, green-blue; ties keep the first
					edge_point(gamut[0], gamut[1], gamut[2], gamut[3], cx, cy, ex, ey);
					edge_point(gamut[4], gamut[5], gamut[0], gamut[1], cx, cy, fx, fy);
					edge_point(gamut[2], gamut[3], gamut[4], gamut[5], cx, cy, hx, hy);
					de = (cx - ex) * (cx - ex) + (cy - ey) * (cy - ey);
					df = (cx - fx) * (cx - fx) + (cy - fy) * (cy - fy);
					dh = (cx - hx) * (cx - hx) + (cy - hy) * (cy - hy);
					best = de; nx = ex; ny = ey;
					if (df < best) begin best = df; nx = fx; ny = fy; end
					if (dh < best) begin nx = hx; ny = hy; end
					cx = nx;
					cy = ny;
					res.clamped = 1;
				end
			end
			res.on = !(off_black && lvl == 0);
			m = lvl * 254;
			if (m < 65536) m = 65536;
			p = factor * m;
			if (p > (64'd254 << 24)) p = 64'd254 << 24;
			lamp = (p + (64'd1 << 23)) >> 24;
			if (!res.on) lamp = 0;
			res.cx = cx[F-1:0];
			res.cy = cy[F-1:0];
			res.level = lvl[15:0];
			res.lamp = lamp[7:0];
			pending = {pending, res};
		endfunction

		task report(string what, longint got, longint want);
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check(xy_result_t got);
			xy_result_t want;
			if (pending.size() == 0) begin
				report("unexpected beat", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.cx !== want.cx) report("chroma_x", got.cx, want.cx);
			if (got.cy !== want.cy) report("chroma_y", got.cy, want.cy);
			if (got.level !== want.level) report("linear_level", got.level, want.level);
			if (got.lamp !== want.lamp) report("lamp_level", got.lamp, want.lamp);
			if (got.on !== want.on) report("lamp_on", got.on, want.on);
			if (got.clamped !== want.clamped) report("was_clamped", got.clamped, want.clamped);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write_en = 0;
	logic [rgbxy_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [7:0] red = 0, green = 0, blue = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [F-1:0] chroma_x, chroma_y;
	logic [15:0] linear_level;
	logic [7:0] lamp_level;
	logic lamp_on, was_clamped;

	xy_scoreboard sb = new();
	bit quiet = 0;
	int hold_req = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	rgb_to_xy_gamut_clamp #(.COORD_FRAC_BITS(F)) DUT (.*);

	// handshake inputs only move at the rising edge, so the falling edge sees the beat
	always @(negedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note(red, green, blue);
		if (arst_n && out_valid && out_ready)
			sb.check('{chroma_x, chroma_y, linear_level, lamp_level, lamp_on, was_clamped});
	end

	function int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver side
	initial begin
		int stall;
		int held;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				held = 0;
				out_ready <= 0;
				while (held < hold_req) begin
					@(posedge clk);
					held++;
				end
				hold_req = 0;
			end
			if (stall > 0) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
				stall = gap_len();
			end
		end
	end

	task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		red <= r;
		green <= g;
		blue <= b;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	function logic [7:0] chan_value();
		logic [7:0] pick[6] = '{0, 1, 10, 11, 254, 255};
		if ($urandom_range(0, 4) == 0)
			return pick[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	task cfg_write(logic [rgbxy_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_write_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task load_gamut(longint rx, longint ry, longint gx, longint gy, longint bx, longint by,
			longint fac, bit offb);
		cfg_write(rgbxy_pkg::CFG_RED_X, 16'(rx));
		cfg_write(rgbxy_pkg::CFG_RED_Y, 16'(ry));
		cfg_write(rgbxy_pkg::CFG_GREEN_X, 16'(gx));
		cfg_write(rgbxy_pkg::CFG_GREEN_Y, 16'(gy));
		cfg_write(rgbxy_pkg::CFG_BLUE_X, 16'(bx));
		cfg_write(rgbxy_pkg::CFG_BLUE_Y, 16'(by));
		cfg_write(rgbxy_pkg::CFG_FACTOR, 16'(fac));
		cfg_write(rgbxy_pkg::CFG_OFF_ON_BLACK, 16'(offb));
		cfg_write_en <= 0;
	endtask

	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: black, white, primaries, secondaries, linear/curve boundary, grays
		send_pixel(0, 0, 0);
		send_pixel(255, 255, 255);
		send_pixel(255, 0, 0);
		send_pixel(0, 255, 0);
		send_pixel(0, 0, 255);
		send_pixel(255, 255, 0);
		send_pixel(0, 255, 255);
		send_pixel(255, 0, 255);
		send_pixel(10, 0, 0);
		send_pixel(0, 11, 0);
		send_pixel(0, 0, 1);
		send_pixel(1, 1, 1);
		send_pixel(128, 128, 128);
		send_pixel(170, 85, 85);
		drain();
		// lamp stays on for black, factor zero
		load_gamut(46137, 19399, 14097, 46570, 9044, 5243, 0, 0);
		send_pixel(0, 0, 0);
		send_pixel(255, 255, 255);
		send_pixel(40, 200, 7);
		drain();
		// collinear corners: every non-black pixel clamps; zero-length edges from a single point
		load_gamut(1000, 1000, 1000, 1000, 1000, 1000, 65535, 1);
		send_pixel(255, 255, 255);
		send_pixel(0, 0, 0);
		send_pixel(255, 0, 0);
		drain();
		load_gamut(0, 0, 30000, 30000, 60000, 60000, 512, 1);
		send_pixel(0, 0, 255);
		send_pixel(0, 255, 0);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: load_gamut(46137, 19399, 14097, 46570, 9044, 5243, 256, 1);
				1: load_gamut(9044, 5243, 14097, 46570, 46137, 19399, 65535, 0);
				2: load_gamut(0, 0, 0, 0, 0, 0, 0, 1);
				3: load_gamut(65535, 65535, 65535, 0, 0, 65535, 1, 0);
				default: load_gamut($urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 1));
			endcase
			quiet = (ph == 1 || ph == 4);
			if (ph == 4)
				hold_req = 300;
			for (n = 0; n < 70; n++) begin
				if (ph == 2 && n == 35) begin
					in_valid <= 0;
					while (sb.pending.size() != 0) @(posedge clk);
					@(posedge clk);
				end
				if ($urandom_range(0, 19) == 0)
					send_pixel(0, 0, 0);
				else
					send_pixel(chan_value(), chan_value(), chan_value());
			end
			quiet = 0;
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
